@@ src/fbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants for the fixed-size block free-list allocator:
// field widths, register indexes, request and status codes, controller states.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    // field widths
    localparam int OP_W        = 1;
    localparam int OFFS_W      = 22;
    localparam int BSIZE_W     = 13;
    localparam int COUNT_W     = 11;
    localparam int STATUS_W    = 2;
    localparam int OUT_INDEX_W = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int DIV_CNT_W   = $clog2(OFFS_W);

    // pool limits and reset values
    localparam int DEFAULT_MAX_BLOCKS  = 1024;
    localparam int BLOCK_SIZE_MAX      = 4096;
    localparam int RESET_BLOCK_SIZE    = 64;
    localparam int RESET_BLOCK_COUNT   = 1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    // request codes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC_RD,
        S_DIV,
        S_FREE_CHK,
        S_FINISH
    } fbfl_state_t;

endpackage

@@ src/fbfl_ram.sv @@
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/fixed_block_free_list_top.sv @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_top
// Fixed-size block allocator: a linked free list held in a link RAM, pop on
// allocate, restoring division of the offset and push on free.
// ----------------------------------------------------------------------------
// One request is in flight at a time. An allocate goes through a link RAM
// read, then the result; when the pool is empty it goes straight to the
// result. A free passes the offset through a bit-serial restoring divider,
// one quotient bit per cycle, then through the range check and link write
// and finally the hand-off of the result.
// The result register lets the next request be accepted while a result
// still waits to be taken. After reset, and after every write of the block
// count register, the link RAM is rebuilt by a pass over all MAX_BLOCKS
// entries during which no request is accepted; configuration writes are
// taken at any time.
module fixed_block_free_list_top #(
    parameter int MAX_BLOCKS = fbfl_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [fbfl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fbfl_pkg::OP_W-1:0]          operation,
    input  logic [fbfl_pkg::OFFS_W-1:0]        free_offset,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fbfl_pkg::STATUS_W-1:0]      status,
    output logic [fbfl_pkg::OFFS_W-1:0]        block_offset,
    output logic [fbfl_pkg::OUT_INDEX_W-1:0]   block_index,
    output logic [fbfl_pkg::COUNT_W-1:0]       outstanding,
    output logic                               none_outstanding
);

    import fbfl_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = IDX_W + BSIZE_W;
    localparam int CNT_RESET = (RESET_BLOCK_COUNT > MAX_BLOCKS) ? MAX_BLOCKS
                                                                : RESET_BLOCK_COUNT;
    localparam logic [LINK_W-1:0] LINK_NONE  = LINK_W'(MAX_BLOCKS);
    localparam logic [LINK_W-1:0] SWEEP_LAST = LINK_W'(MAX_BLOCKS - 1);

    // control state
    fbfl_state_t          state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [BSIZE_W-1:0]   bsize_reg, bsize_next;
    logic [LINK_W-1:0]    cnt_lim_reg, cnt_lim_next;
    logic [LINK_W-1:0]    sweep_reg, sweep_next;

    // datapath registers
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [OFFS_W-1:0]      div_q_reg, div_q_next;
    logic [BSIZE_W-1:0]     div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [OFFS_W-1:0]      res_offset_reg, res_offset_next;
    logic [OUT_INDEX_W-1:0] res_index_reg, res_index_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [OFFS_W-1:0]      out_offset_reg, out_offset_next;
    logic [OUT_INDEX_W-1:0] out_index_reg, out_index_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                   out_none_reg, out_none_next;

    // link RAM port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    // helper signals
    logic                      cfg_count_wr;
    logic [BSIZE_W-1:0]        cfg_bsize_eff;
    logic [LINK_W-1:0]         cfg_count_eff;
    logic [COUNT_W-1:0]        cfg_count_raw;
    logic                      pool_empty;
    logic                      result_load;
    logic                      sweep_done;
    logic [LINK_W-1:0]         sweep_succ;
    logic [LINK_W-1:0]         sweep_link;
    logic [BSIZE_W:0]          div_trial;
    logic                      div_ge;
    logic [BSIZE_W:0]          div_diff;
    logic                      free_misaligned;
    logic                      free_outside;
    logic                      free_ok;
    logic [IDX_W-1:0]          free_idx;
    logic [PROD_W-1:0]         alloc_prod;
    logic [PROD_W+OFFS_W-1:0]  alloc_prod_ext;
    logic [IDX_W+OUT_INDEX_W-1:0] alloc_idx_ext;
    logic [IDX_W+OUT_INDEX_W-1:0] free_idx_ext;

    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration value clamping
    assign cfg_count_raw = cfg_data[COUNT_W-1:0];
    assign cfg_count_wr  = cfg_we && (cfg_index == CFG_BLOCK_COUNT);

    always_comb
    begin
        if (cfg_data == '0)
            cfg_bsize_eff = BSIZE_W'(1);
        else if (32'(cfg_data) > 32'(BLOCK_SIZE_MAX))
            cfg_bsize_eff = BSIZE_W'(BLOCK_SIZE_MAX);
        else
            cfg_bsize_eff = cfg_data;

        if (cfg_count_raw == '0)
            cfg_count_eff = LINK_W'(1);
        else if (32'(cfg_count_raw) > 32'(MAX_BLOCKS))
            cfg_count_eff = LINK_W'(MAX_BLOCKS);
        else
            cfg_count_eff = LINK_W'(32'(cfg_count_raw));
    end

    // shared status terms
    assign pool_empty  = (head_reg >= LINK_NONE);
    assign result_load = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign sweep_done  = (sweep_reg == SWEEP_LAST);
    assign sweep_succ  = sweep_reg + LINK_W'(1);
    assign sweep_link  = (sweep_succ < cnt_lim_reg) ? sweep_succ : LINK_NONE;

    // one restoring division step
    assign div_trial = {div_rem_reg, div_q_reg[OFFS_W-1]};
    assign div_ge    = (div_trial >= {1'b0, bsize_reg});
    assign div_diff  = div_trial - {1'b0, bsize_reg};

    // free checks on the finished quotient and remainder
    assign free_misaligned = (div_rem_reg != '0);
    assign free_outside    = (32'(div_q_reg) >= 32'(cnt_lim_reg));
    assign free_ok         = !free_misaligned && !free_outside;
    assign free_idx        = div_q_reg[IDX_W-1:0];

    // allocation offset, multiplier inputs are registers
    assign alloc_prod     = idx_reg * bsize_reg;
    assign alloc_prod_ext = {{OFFS_W{1'b0}}, alloc_prod};
    assign alloc_idx_ext  = {{OUT_INDEX_W{1'b0}}, idx_reg};
    assign free_idx_ext   = {{OUT_INDEX_W{1'b0}}, free_idx};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sweep_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_FREE)
                        state_next = S_DIV;
                    else if (pool_empty)
                        state_next = S_FINISH;
                    else
                        state_next = S_ALLOC_RD;
                end
            end
            S_ALLOC_RD:
            begin
                state_next = S_FINISH;
            end
            S_DIV:
            begin
                if (div_cnt_reg == '0)
                    state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (result_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        // a block count write restarts the chain rebuild
        if (cfg_count_wr)
            state_next = S_INIT;
    end

    // state outputs: handshake and link RAM controls
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = sweep_reg[IDX_W-1:0];
        ram_wdata = sweep_link;
        ram_raddr = head_reg[IDX_W-1:0];
        unique case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_FREE_CHK:
            begin
                ram_we    = free_ok;
                ram_waddr = free_idx;
                ram_wdata = head_reg;
            end
            S_ALLOC_RD, S_DIV, S_FINISH:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        bsize_next      = bsize_reg;
        cnt_lim_next    = cnt_lim_reg;
        sweep_next      = sweep_reg;
        idx_next        = idx_reg;
        div_q_next      = div_q_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        out_none_next   = out_none_reg;

        case (state_reg)
            // rebuild pass over the link RAM
            S_INIT:
            begin
                sweep_next = sweep_succ;
            end
            // request transfer
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_FREE)
                    begin
                        div_q_next   = free_offset;
                        div_rem_next = '0;
                        div_cnt_next = DIV_CNT_W'(OFFS_W - 1);
                    end
                    else if (pool_empty)
                    begin
                        res_status_next = ST_EMPTY;
                        res_offset_next = '0;
                        res_index_next  = '0;
                    end
                    else
                    begin
                        idx_next = head_reg[IDX_W-1:0];
                    end
                end
            end
            // pop: link of the head becomes the new head
            S_ALLOC_RD:
            begin
                head_next = ram_rdata;
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + COUNT_W'(1);
                res_status_next = ST_OK;
                res_offset_next = alloc_prod_ext[OFFS_W-1:0];
                res_index_next  = alloc_idx_ext[OUT_INDEX_W-1:0];
            end
            // one quotient bit per cycle
            S_DIV:
            begin
                div_q_next   = {div_q_reg[OFFS_W-2:0], div_ge};
                div_rem_next = div_ge ? div_diff[BSIZE_W-1:0] : div_trial[BSIZE_W-1:0];
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            end
            // range check and push
            S_FREE_CHK:
            begin
                res_offset_next = '0;
                res_index_next  = '0;
                if (free_misaligned)
                    res_status_next = ST_MISALIGNED;
                else if (free_outside)
                    res_status_next = ST_OUTSIDE;
                else
                begin
                    res_status_next = ST_OK;
                    res_index_next  = free_idx_ext[OUT_INDEX_W-1:0];
                    head_next       = LINK_W'(free_idx);
                    if (count_reg != '0)
                        count_next = count_reg - COUNT_W'(1);
                end
            end
            // hand result to the output register
            S_FINISH:
            begin
                if (result_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_offset_next = res_offset_reg;
                    out_index_next  = res_index_reg;
                    out_count_next  = count_reg;
                    out_none_next   = (count_reg == '0);
                end
            end
            default:
            begin
                sweep_next = sweep_reg;
            end
        endcase

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_SIZE:
                begin
                    bsize_next = cfg_bsize_eff;
                end
                CFG_BLOCK_COUNT:
                begin
                    cnt_lim_next = cfg_count_eff;
                    head_next    = '0;
                    count_next   = '0;
                    sweep_next   = '0;
                end
                default:
                begin
                    bsize_next = bsize_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            bsize_reg     <= BSIZE_W'(RESET_BLOCK_SIZE);
            cnt_lim_reg   <= LINK_W'(CNT_RESET);
            sweep_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            bsize_reg     <= bsize_next;
            cnt_lim_reg   <= cnt_lim_next;
            sweep_reg     <= sweep_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        div_q_reg      <= div_q_next;
        div_rem_reg    <= div_rem_next;
        div_cnt_reg    <= div_cnt_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
        out_none_reg   <= out_none_next;
    end

    // result ports
    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign block_offset     = out_offset_reg;
    assign block_index      = out_index_reg;
    assign outstanding      = out_count_reg;
    assign none_outstanding = out_none_reg;

    // head is always a block inside the pool or the end marker
    a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == LINK_NONE) || (head_reg < cnt_lim_reg))
        else $error("free list head outside the pool");

    // link RAM is written only by the rebuild pass or a push
    a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_INIT) || (state_reg == S_FREE_CHK)))
        else $error("link RAM written outside rebuild or push");

    // a pop raises the outstanding count unless it is saturated
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ALLOC_RD) && (count_reg != COUNT_MAX) && !cfg_count_wr)
        |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("allocate did not raise the outstanding count");

    // the divider hands over to the check after its last step
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && (div_cnt_reg == '0) && !cfg_count_wr)
        |=> (state_reg == S_FREE_CHK))
        else $error("divider did not finish on its last step");

endmodule
